FILE: src/ttq_pkg.sv
// shared types, codes and constants for the table threshold quantizer
// no dependencies; used by ttq_ctrl, ttq_datapath and table_threshold_quantizer
`default_nettype none

package ttq_pkg;

  // default table depth
  localparam int MAX_LEVELS_DEF = 16;

  // field widths fixed by the interface
  localparam int REQ_W    = 2;
  localparam int TIDX_W   = 4;
  localparam int VAL_W    = 16;
  localparam int LIDX_W   = 4;
  localparam int LCNT_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // request kinds carried in in_tuser
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_THRESH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LEVEL  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'd1;

  // reset value of level_count
  localparam logic [LCNT_W-1:0] LEVEL_COUNT_RST = 5'd2;

  // q2.14 clamp bounds
  localparam logic signed [VAL_W-1:0] Q_POS_ONE = 16'sd16384;
  localparam logic signed [VAL_W-1:0] Q_NEG_ONE = -16'sd16384;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture a sample beat and start a search
    logic wr;        // table write beat
    logic rd;        // read next threshold entry
    logic lvl;       // resolve the search and read the level table
    logic out_load;  // move the result into the output register
  } ttq_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rd_last;   // threshold read address is the top entry in use
    logic out_free;  // output register can take a result this cycle
  } ttq_sts_t;

endpackage

`default_nettype wire

FILE: src/table_threshold_quantizer.sv
// top level of the non-uniform table threshold quantizer; depends on ttq_pkg,
// ttq_ctrl and ttq_datapath
// table write beat: no result; a new beat can follow next cycle
// sample beat: the next beat is accepted only after the result has moved into the
//   output register, so also held while the finished result waits for it to drain;
//   the result comes from the serial threshold scan (one table read per cycle)
//   followed by the level table read
// reset: state machine idle, output empty, saturate off, level count 2;
//   both tables hold unknown values until written
`default_nettype none

module table_threshold_quantizer #(
  parameter int MAX_LEVELS = ttq_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_wr_en,
  input  wire logic [ttq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ttq_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input beats
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // table_index [3:0], entry_value [19:4], sample [35:20], zero pad [39:36]
  input  wire logic [ttq_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type [1:0]
  input  wire logic [ttq_pkg::REQ_W-1:0]       in_tuser,
  // last_sample
  input  wire logic                            in_tlast,
  // result beats
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // level_value [15:0], level_index [19:16], zero pad [23:20]
  output logic [ttq_pkg::OUT_DATA_W-1:0]       out_tdata,
  // no_level_error
  output logic                                 out_tuser,
  // end_of_block
  output logic                                 out_tlast
);

  ttq_pkg::ttq_cmd_t cmd;
  ttq_pkg::ttq_sts_t sts;

  // state machine: accepts beats only while idle, sequences scan and level read
  ttq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // tables, compare, output register
  ttq_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  // a sample beat starts a search, so no beat is taken in the next cycle
  a_sample_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == ttq_pkg::REQ_SAMPLE)) |=> !in_tready)
    else $error("beat accepted right after a sample beat");

  // a result never overwrites one still waiting downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register overwritten while full");

  // table writes only happen while no search is reading the tables
  a_wr_not_during_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !(cmd.rd || cmd.lvl))
    else $error("table write during search");

endmodule

`default_nettype wire

FILE: src/ttq_ctrl.sv
// controller state machine for the table threshold quantizer
// depends on ttq_pkg; drives ttq_datapath through ttq_cmd_t
`default_nettype none

module ttq_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  input  wire logic [ttq_pkg::REQ_W-1:0]   in_tuser,
  output logic                             in_tready,
  input  wire ttq_pkg::ttq_sts_t           sts,
  output ttq_pkg::ttq_cmd_t                cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_LEVEL  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_tuser) inside
            ttq_pkg::REQ_SAMPLE: begin
              cmd.load  = 1'b1;
              state_nxt = ST_SCAN;
            end
            ttq_pkg::REQ_THRESH, ttq_pkg::REQ_LEVEL: begin
              cmd.wr = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (sts.rd_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd.lvl   = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/ttq_datapath.sv
// datapath: config registers, threshold and level tables, serial search, output register
// depends on ttq_pkg; sequenced by ttq_ctrl
`default_nettype none

module ttq_datapath #(
  parameter int MAX_LEVELS = ttq_pkg::MAX_LEVELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [ttq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ttq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [ttq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [ttq_pkg::REQ_W-1:0]        in_tuser,
  input  wire logic                             in_tlast,
  input  wire logic                             out_tready,
  output logic                                  out_tvalid,
  output logic [ttq_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tuser,
  output logic                                  out_tlast,
  input  wire ttq_pkg::ttq_cmd_t                cmd,
  output ttq_pkg::ttq_sts_t                     sts
);

  localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

  // configuration
  logic                            sat_en_r;
  logic [ttq_pkg::LCNT_W-1:0]      lvl_cnt_r;

  // tables
  logic signed [ttq_pkg::VAL_W-1:0] thr_mem [MAX_LEVELS];
  logic signed [ttq_pkg::VAL_W-1:0] lvl_mem [MAX_LEVELS];
  logic signed [ttq_pkg::VAL_W-1:0] thr_q_r;
  logic signed [ttq_pkg::VAL_W-1:0] lvl_q_r;

  // input fields
  logic [ttq_pkg::TIDX_W-1:0]       f_idx;
  logic signed [ttq_pkg::VAL_W-1:0] f_val;
  logic signed [ttq_pkg::VAL_W-1:0] f_smp;
  logic signed [ttq_pkg::VAL_W-1:0] smp_clamped;
  logic [31:0]                      widx32;
  logic [IDX_W-1:0]                 waddr;
  logic                             widx_ok;
  logic [31:0]                      lc32;
  logic [IDX_W-1:0]                 nm1;

  // search state
  logic signed [ttq_pkg::VAL_W-1:0] s_r;
  logic [IDX_W-1:0]                 nm1_r;
  logic                             last_r;
  logic [IDX_W-1:0]                 rd_idx_r;
  logic [IDX_W-1:0]                 cmp_idx_r;
  logic                             cmp_vld_r;
  logic                             le1_r;
  logic                             gt_prev_r;
  logic                             found_r;
  logic [IDX_W-1:0]                 found_idx_r;
  logic                             gt;

  // resolved choice
  logic [IDX_W-1:0]                 chosen;
  logic                             err;
  logic [IDX_W-1:0]                 chosen_r;
  logic                             err_r;
  logic [31:0]                      ch32;

  // output register
  logic                             out_vld_r;
  logic signed [ttq_pkg::VAL_W-1:0] o_val_r;
  logic [ttq_pkg::LIDX_W-1:0]       o_idx_r;
  logic                             o_err_r;
  logic                             o_last_r;

  assign f_idx = in_tdata[3:0];
  assign f_val = in_tdata[19:4];
  assign f_smp = in_tdata[35:20];

  assign widx32  = 32'(f_idx);
  assign waddr   = widx32[IDX_W-1:0];
  assign widx_ok = (widx32 < 32'(MAX_LEVELS));

  always_comb begin
    smp_clamped = f_smp;
    if (sat_en_r) begin
      if (f_smp > ttq_pkg::Q_POS_ONE) begin
        smp_clamped = ttq_pkg::Q_POS_ONE;
      end else if (f_smp < ttq_pkg::Q_NEG_ONE) begin
        smp_clamped = ttq_pkg::Q_NEG_ONE;
      end
    end
  end

  // level count clamped to [2, MAX_LEVELS], kept as n-1
  assign lc32 = 32'(lvl_cnt_r);
  always_comb begin
    if (lc32 < 32'd2) begin
      nm1 = IDX_W'(1);
    end else if (lc32 > 32'(MAX_LEVELS)) begin
      nm1 = IDX_W'(MAX_LEVELS - 1);
    end else begin
      nm1 = IDX_W'(lc32 - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_en_r  <= 1'b0;
      lvl_cnt_r <= ttq_pkg::LEVEL_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ttq_pkg::CFG_SATURATE:    sat_en_r  <= cfg_wdata[0];
        ttq_pkg::CFG_LEVEL_COUNT: lvl_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // table writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr && widx_ok && (in_tuser == ttq_pkg::REQ_THRESH)) begin
      thr_mem[waddr] <= f_val;
    end
    if (cmd.rd) begin
      thr_q_r <= thr_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && widx_ok && (in_tuser == ttq_pkg::REQ_LEVEL)) begin
      lvl_mem[waddr] <= f_val;
    end
    if (cmd.lvl) begin
      lvl_q_r <= lvl_mem[chosen];
    end
  end

  assign gt = (s_r > thr_q_r);

  // serial scan over thresholds 1 .. n-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r      <= smp_clamped;
      nm1_r    <= nm1;
      last_r   <= in_tlast;
      rd_idx_r <= IDX_W'(1);
      found_r  <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_idx_r  <= rd_idx_r + IDX_W'(1);
        cmp_idx_r <= rd_idx_r;
      end
      if (cmp_vld_r) begin
        gt_prev_r <= gt;
        if (cmp_idx_r == IDX_W'(1)) begin
          le1_r <= !gt;
        end else if (!found_r && gt_prev_r && !gt) begin
          found_r     <= 1'b1;
          found_idx_r <= cmp_idx_r - IDX_W'(1);
        end
      end
    end
  end

  // bottom interval first, then above the top threshold, then the scan hit
  always_comb begin
    err = 1'b0;
    if (le1_r) begin
      chosen = '0;
    end else if (gt_prev_r) begin
      chosen = nm1_r;
    end else if (found_r) begin
      chosen = found_idx_r;
    end else begin
      chosen = '0;
      err    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lvl) begin
      chosen_r <= chosen;
      err_r    <= err;
    end
  end

  assign ch32 = 32'(chosen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_val_r  <= err_r ? '0 : lvl_q_r;
      o_idx_r  <= ch32[ttq_pkg::LIDX_W-1:0];
      o_err_r  <= err_r;
      o_last_r <= last_r;
    end
  end

  assign sts.rd_last  = (rd_idx_r == nm1_r);
  assign sts.out_free = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, o_idx_r, o_val_r};
  assign out_tuser  = o_err_r;
  assign out_tlast  = o_last_r;

endmodule

`default_nettype wire

FILE: bench/tb.sv
// self-checking bench for table_threshold_quantizer: streams table writes and samples,
// predicts each chosen level in step with the accepted beats and checks every result
// depends on ttq_pkg and table_threshold_quantizer
`timescale 1ns / 1ps

module tb;

  // request kind the block has no use for, dropped without a result
  localparam logic [ttq_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int SETTLE_CYCLES = 24;     // room for the longest search to finish
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_ITEMS   = 136;
  localparam int STEADY_PHASE  = 4;      // phase run with no idling on either side
  localparam int REPORT_MAX    = 10;

  // one expected result beat
  typedef struct packed {
    logic signed [ttq_pkg::VAL_W-1:0] level_value;
    logic [ttq_pkg::LIDX_W-1:0]       level_index;
    logic                             no_level;
    logic                             end_blk;
  } level_pick_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_wr_en;
  logic [ttq_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ttq_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ttq_pkg::IN_DATA_W-1:0]  in_tdata;   // table_index, entry_value, sample, zero pad
  logic [ttq_pkg::REQ_W-1:0]      in_tuser;   // req_type
  logic                           in_tlast;   // last_sample
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ttq_pkg::OUT_DATA_W-1:0] out_tdata;  // level_value, level_index, zero pad
  logic                           out_tuser;  // no_level_error
  logic                           out_tlast;  // end_of_block

  // bench copy of the block state and registers
  logic signed [ttq_pkg::VAL_W-1:0] thresh_tab [ttq_pkg::MAX_LEVELS_DEF];
  logic signed [ttq_pkg::VAL_W-1:0] level_tab  [ttq_pkg::MAX_LEVELS_DEF];
  logic                             sat_on;
  logic [ttq_pkg::LCNT_W-1:0]       lvl_count;

  level_pick_t picks_due [$];   // chosen levels still owed by the block
  int          mismatch_count = 0;
  bit          steady_flow = 1'b0;

  table_threshold_quantizer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on the whole run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL table_threshold_quantizer");
    $finish;
  end

  // result side stalls at random, with probability 0.13, except in the steady phase
  always @(negedge clk) begin
    out_tready <= steady_flow || ($urandom_range(0, 99) >= 13);
  end

  // level search: clamp if enabled, then the first threshold interval that holds the sample
  function automatic level_pick_t pick_level(logic signed [ttq_pkg::VAL_W-1:0] smp,
                                             logic last);
    logic signed [ttq_pkg::VAL_W-1:0] s;
    int          n;
    int          pick;
    bit          hit;
    level_pick_t r;
    s = smp;
    if (sat_on) begin
      if (s > ttq_pkg::Q_POS_ONE) s = ttq_pkg::Q_POS_ONE;
      if (s < ttq_pkg::Q_NEG_ONE) s = ttq_pkg::Q_NEG_ONE;
    end
    // level count outside 2..16 acts as the nearest bound
    n = lvl_count;
    if (n < 2) n = 2;
    if (n > ttq_pkg::MAX_LEVELS_DEF) n = ttq_pkg::MAX_LEVELS_DEF;
    pick = 0;
    hit  = 1'b1;
    if (s <= thresh_tab[1]) begin
      pick = 0;
    end else if (s > thresh_tab[n-1]) begin
      pick = n - 1;
    end else begin
      // only unsorted thresholds could leave this without a hit
      hit = 1'b0;
      for (int j = 1; j + 1 < n; j++) begin
        if (!hit && s > thresh_tab[j] && s <= thresh_tab[j+1]) begin
          pick = j;
          hit  = 1'b1;
        end
      end
    end
    r.level_value = hit ? level_tab[pick] : '0;
    r.level_index = hit ? pick[ttq_pkg::LIDX_W-1:0] : '0;
    r.no_level    = !hit;
    r.end_blk     = last;
    return r;
  endfunction

  // compare each accepted result beat with the oldest expected one
  always @(posedge clk) begin : result_check
    level_pick_t want;
    level_pick_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.level_value = out_tdata[ttq_pkg::VAL_W-1:0];
      got.level_index = out_tdata[ttq_pkg::VAL_W+ttq_pkg::LIDX_W-1:ttq_pkg::VAL_W];
      got.no_level    = out_tuser;
      got.end_blk     = out_tlast;
      if (picks_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: result beat with nothing expected: level %0d index %0d err %0b eob %0b",
                   $time, got.level_value, got.level_index, got.no_level, got.end_blk);
      end else begin
        want = picks_due.pop_front();
        if (got.level_value !== want.level_value || got.level_index !== want.level_index ||
            got.no_level !== want.no_level || got.end_blk !== want.end_blk) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: mismatch exp/act level %0d/%0d index %0d/%0d err %0b/%0b eob %0b/%0b",
                     $time, want.level_value, got.level_value, want.level_index,
                     got.level_index, want.no_level, got.no_level, want.end_blk, got.end_blk);
        end
      end
    end
  end

  // one input beat; starts and ends just after a falling edge, valid left high
  task automatic send_beat(logic [ttq_pkg::REQ_W-1:0] req, logic [ttq_pkg::TIDX_W-1:0] idx,
                           logic [ttq_pkg::VAL_W-1:0] entry, logic [ttq_pkg::VAL_W-1:0] smp,
                           logic last);
    // random idle gap before the beat
    if (!steady_flow && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ttq_pkg::IN_DATA_W - 2*ttq_pkg::VAL_W - ttq_pkg::TIDX_W){1'b0}},
                  smp, entry, idx};
    in_tuser  <= req;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // beat taken: update the bench state in acceptance order
    case (req)
      ttq_pkg::REQ_THRESH: thresh_tab[idx] = entry;
      ttq_pkg::REQ_LEVEL:  level_tab[idx]  = entry;
      ttq_pkg::REQ_SAMPLE: picks_due.push_back(pick_level(smp, last));
      default: ;  // unused kind, no result
    endcase
    @(negedge clk);
  endtask

  // stop sending, let every owed result arrive and the search engine go quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (picks_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write, only called with the block idle
  task automatic write_reg(logic [ttq_pkg::CFG_IDX_W-1:0] idx,
                           logic [ttq_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == ttq_pkg::CFG_SATURATE) sat_on = val[0];
    else lvl_count = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // fill every threshold and level entry: fixed ramp or random rising thresholds
  task automatic load_tables(bit rand_fill);
    int                        t;
    logic [ttq_pkg::VAL_W-1:0] v;
    t = rand_fill ? -32768 + int'($urandom_range(0, 4000)) : -24000;
    for (int k = 0; k < ttq_pkg::MAX_LEVELS_DEF; k++) begin
      v = t;
      send_beat(ttq_pkg::REQ_THRESH, k[ttq_pkg::TIDX_W-1:0], v, $urandom,
                $urandom_range(0, 1));
      t += rand_fill ? int'($urandom_range(0, 4000)) : 3000;
    end
    for (int k = 0; k < ttq_pkg::MAX_LEVELS_DEF; k++) begin
      // fixed ramp puts the value extremes at the two ends
      if (rand_fill) v = $urandom;
      else if (k == 0) v = 16'h8000;
      else if (k == ttq_pkg::MAX_LEVELS_DEF - 1) v = 16'h7fff;
      else v = -22500 + 3000 * k;
      send_beat(ttq_pkg::REQ_LEVEL, k[ttq_pkg::TIDX_W-1:0], v, $urandom,
                $urandom_range(0, 1));
    end
  endtask

  // all entries written before any sample reads them
  task automatic test_table_load();
    load_tables(1'b0);
  endtask

  // sample extremes and samples sitting exactly on and just past thresholds
  task automatic test_sample_extremes();
    wait_idle();
    write_reg(ttq_pkg::CFG_SATURATE, 0);
    write_reg(ttq_pkg::CFG_LEVEL_COUNT, 16);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'hf, 16'hffff, 16'h8000, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 16'h7fff, 1'b1);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'ha, 16'h5555, -21000, 1'b0);   // on threshold 1
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h5, 16'haaaa, -20999, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h3, 16'h1234, 0, 1'b0);        // on a middle threshold
    send_beat(ttq_pkg::REQ_SAMPLE, 4'hc, 16'hfedc, 21000, 1'b0);    // on the top threshold
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h9, 16'h0f0f, 21001, 1'b1);
  endtask

  // clamp to +-1.0 ahead of the search
  task automatic test_saturate();
    wait_idle();
    write_reg(ttq_pkg::CFG_SATURATE, 1);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 16'h7fff, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 16'h8000, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 16385, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, -16385, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, -16384, 1'b1);
  endtask

  // level counts below 2 and above 16 act as the nearest bound
  task automatic test_level_count_range();
    logic [ttq_pkg::CFG_DATA_W-1:0] counts [4];
    counts = '{5'd0, 5'd1, 5'd17, 5'd31};
    wait_idle();
    write_reg(ttq_pkg::CFG_SATURATE, 0);
    foreach (counts[i]) begin
      wait_idle();
      write_reg(ttq_pkg::CFG_LEVEL_COUNT, counts[i]);
      send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 16'h7fff, 1'b0);
      send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, thresh_tab[counts[i] < 2 ? 1 : 15],
                1'b1);
    end
  endtask

  // unused request kind must be swallowed with no result
  task automatic test_ignored_request();
    wait_idle();
    write_reg(ttq_pkg::CFG_LEVEL_COUNT, 16);
    repeat (3) send_beat(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 12345, 1'b0);
  endtask

  // thresholds out of order, then back to the ramp
  task automatic test_unsorted_table();
    wait_idle();
    write_reg(ttq_pkg::CFG_LEVEL_COUNT, 4);
    send_beat(ttq_pkg::REQ_THRESH, 4'd1, 5000, 16'h0000, 1'b0);
    send_beat(ttq_pkg::REQ_THRESH, 4'd2, -5000, 16'h0000, 1'b0);
    send_beat(ttq_pkg::REQ_THRESH, 4'd3, 2000, 16'h0000, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 3000, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, -4000, 1'b0);
    send_beat(ttq_pkg::REQ_SAMPLE, 4'h0, 16'h0000, 5001, 1'b1);
    load_tables(1'b0);
  endtask

  // random phases: fresh settings, mostly sorted tables, samples spread and near thresholds
  task automatic test_random_stream();
    int                             roll;
    int                             k;
    int                             v;
    logic [ttq_pkg::VAL_W-1:0]      smp;
    logic [ttq_pkg::CFG_DATA_W-1:0] lc;
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      steady_flow = (p == STEADY_PHASE);
      if (p == 0) lc = 16;
      else if (p == 1) lc = 2;
      else if ($urandom_range(0, 4) == 0) lc = $urandom_range(0, 31);
      else lc = $urandom_range(2, 16);
      write_reg(ttq_pkg::CFG_SATURATE, $urandom_range(0, 1));
      write_reg(ttq_pkg::CFG_LEVEL_COUNT, lc);
      if ($urandom_range(0, 9) < 6) load_tables(1'b1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          if ($urandom_range(0, 1)) begin
            smp = $urandom;
          end else begin
            // one step below, on, or above a threshold
            k = $urandom_range(1, ttq_pkg::MAX_LEVELS_DEF - 1);
            v = int'(thresh_tab[k]) + int'($urandom_range(0, 2)) - 1;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            smp = v;
          end
          send_beat(ttq_pkg::REQ_SAMPLE, $urandom, $urandom, smp, $urandom_range(0, 7) == 0);
        end else if (roll < 86) begin
          send_beat(ttq_pkg::REQ_THRESH, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        end else if (roll < 95) begin
          send_beat(ttq_pkg::REQ_LEVEL, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        end else begin
          send_beat(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        end
        // now and then hold the stream until the block has emptied
        if ($urandom_range(0, 199) == 0) wait_idle();
      end
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ttq_pkg::REQ_SAMPLE;
    in_tlast  = 1'b0;
    sat_on    = 1'b0;
    lvl_count = ttq_pkg::LEVEL_COUNT_RST;
    foreach (thresh_tab[i]) begin
      thresh_tab[i] = '0;
      level_tab[i]  = '0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_table_load();
    test_sample_extremes();
    test_saturate();
    test_level_count_range();
    test_ignored_request();
    test_unsorted_table();
    test_random_stream();

    wait_idle();
    if (mismatch_count == 0 && picks_due.size() == 0) begin
      $display("PASS table_threshold_quantizer");
    end else begin
      $display("FAIL table_threshold_quantizer");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ttq_pkg.sv
src/ttq_ctrl.sv
src/ttq_datapath.sv
src/table_threshold_quantizer.sv
bench/tb.sv
